### rtl/hpgm_pkg.sv
// hpgm_pkg: shared types and constants for the hit pattern group matcher
// no dependencies; imported by every module under rtl
package hpgm_pkg;

   localparam int unsigned HASH_W      = 16;
   localparam int unsigned GROUP_W     = 6;
   localparam int unsigned LAYER_W     = 3;
   localparam int unsigned CFG_W       = 4;
   localparam int unsigned LAYER_LIMIT = 8;
   localparam int unsigned ACTION_W    = 2;
   localparam int unsigned CSR_INDEX_W = 2;

   // transaction action codes, code 3 is ignored
   localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_HIT  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_EOE  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_REQUIRED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYERS   = 2'd1;

   localparam logic [CFG_W-1:0] REQUIRED_RESET = 4'd7;
   localparam logic [CFG_W-1:0] LAYERS_RESET   = 4'd8;

   // broadcast from the input side to every cell
   typedef struct packed {
      logic               hit;
      logic               load;
      logic [HASH_W-1:0]  hash;
      logic [GROUP_W-1:0] group;
      logic [LAYER_W-1:0] layer;
      logic               wild;
   } bcast_type;

   // match settings shared by all cells
   typedef struct packed {
      logic [CFG_W-1:0]       required;
      logic [LAYER_LIMIT-1:0] used_mask;
   } match_cfg_type;

   // readout status seen by the top level
   typedef struct packed {
      logic busy;
      logic pend_valid;
   } rd_status_type;

   typedef enum logic [2:0] {
      RD_IDLE  = 3'b001,
      RD_SCAN  = 3'b010,
      RD_FLUSH = 3'b100
   } rd_state_type;

endpackage

### rtl/hit_pattern_group_matcher.sv
// hit_pattern_group_matcher: loads and hits are always taken, ends of event may wait
// end of event: captures the match flags, which the scan state walks out and the flush
// state closes; the chain moves one group per cycle unless a new match waits for output
// loads and hits are taken during a readout, a further end of event waits for it,
// so one readout has ended before the next end of event is taken
// reset (synchronous) clears hit marks, settings and readout; pattern words keep no reset
module hit_pattern_group_matcher
   import hpgm_pkg::*;
#(
   parameter int unsigned NUM_GROUPS = 64,
   parameter int unsigned MAX_LAYERS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // input transactions
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [GROUP_W-1:0]     req_group_sel,
   input  logic [LAYER_W-1:0]     req_layer_sel,
   input  logic [HASH_W-1:0]      req_hash_id,
   input  logic                   req_wildcard_req,
   // result transactions
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [GROUP_W-1:0]     rsp_group_index,
   output logic                   rsp_found,
   output logic                   rsp_last,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   logic            req_fire;
   logic            capture;
   logic            shift;
   bcast_type       bcast;
   match_cfg_type   cfg;
   rd_status_type   status;
   logic [CFG_W-1:0] required_ff, required_in;
   logic [CFG_W-1:0] layers_ff, layers_in;
   logic            flag [NUM_GROUPS];

   // an end of event may not start while the previous readout still runs
   assign req_ready = !(status.busy && (req_action == ACT_EOE));
   assign req_fire  = req_valid && req_ready;
   assign capture   = req_fire && (req_action == ACT_EOE);

   // loads and hits go to every cell at once, as in an associative memory
   assign bcast.hit   = req_fire && (req_action == ACT_HIT);
   assign bcast.load  = req_fire && (req_action == ACT_LOAD);
   assign bcast.hash  = req_hash_id;
   assign bcast.group = req_group_sel;
   assign bcast.layer = req_layer_sel;
   assign bcast.wild  = req_wildcard_req;

   // settings registers, writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      required_in = required_ff;
      layers_in   = layers_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_REQUIRED: required_in = csr_wdata;
            CSR_LAYERS:   layers_in   = csr_wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff <= REQUIRED_RESET;
         layers_ff   <= LAYERS_RESET;
      end else begin
         required_ff <= required_in;
         layers_ff   <= layers_in;
      end
   end

   // layers counted: those below the setting, which saturates by itself
   always_comb begin
      cfg.required = required_ff;
      for (int l = 0; l < LAYER_LIMIT; l++) begin
         cfg.used_mask[l] = (CFG_W'(l) < layers_ff);
      end
   end

   // chain of group cells; flags move towards cell 0 during readout
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_cell
      logic flag_next;
      if (g == NUM_GROUPS - 1) begin : g_tail
         assign flag_next = 1'b0;
      end else begin : g_link
         assign flag_next = flag[g+1];
      end
      hpgm_cell #(
         .CELL_IDX   (g),
         .MAX_LAYERS (MAX_LAYERS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .bcast     (bcast),
         .cfg       (cfg),
         .capture   (capture),
         .shift     (shift),
         .flag_next (flag_next),
         .flag      (flag[g])
      );
   end

   // readout in ascending group order with one result held back to place last
   hpgm_readout #(
      .NUM_GROUPS (NUM_GROUPS)
   ) u_readout (
      .clock           (clock),
      .reset           (reset),
      .capture         (capture),
      .head_flag       (flag[0]),
      .shift           (shift),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_group_index (rsp_group_index),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last)
   );

   // the no-match result always closes its event
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last)
      else $error("no-match result without last");

   // an end of event always starts a readout
   a_eoe_starts_scan: assert property (@(posedge clock) disable iff (reset)
      capture |=> status.busy)
      else $error("end of event did not start readout");

   // a result that is not last leaves the readout running
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> status.busy)
      else $error("readout ended before last result");

   // a held-back result only exists during readout
   a_pending_in_scan: assert property (@(posedge clock) disable iff (reset)
      status.pend_valid |-> status.busy)
      else $error("pending result outside readout");

endmodule

### rtl/hpgm_cell.sv
// hpgm_cell: one pattern group, its layer words, hit marks and readout flag
// depends on hpgm_pkg
module hpgm_cell
   import hpgm_pkg::*;
#(
   parameter int unsigned CELL_IDX   = 0,
   parameter int unsigned MAX_LAYERS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  bcast_type     bcast,
   input  match_cfg_type cfg,
   input  logic          capture,
   input  logic          shift,
   input  logic          flag_next,
   output logic          flag
);

   logic [HASH_W-1:0]     hash_ff [MAX_LAYERS];
   logic [MAX_LAYERS-1:0] wild_ff;
   logic [MAX_LAYERS-1:0] marks_ff, marks_in;
   logic [MAX_LAYERS-1:0] wr_vec, hit_vec, layer_ok;
   logic                  sel_group;
   logic [CFG_W-1:0]      count;
   logic                  match;
   logic                  flag_ff, flag_in;

   assign sel_group = (bcast.group == GROUP_W'(CELL_IDX));

   always_comb begin
      for (int l = 0; l < MAX_LAYERS; l++) begin
         wr_vec[l]   = bcast.load && sel_group && (bcast.layer == LAYER_W'(l));
         hit_vec[l]  = bcast.hit && !wild_ff[l] && (hash_ff[l] == bcast.hash);
         layer_ok[l] = cfg.used_mask[l] && (wild_ff[l] || marks_ff[l]);
      end
   end

   // matched layer count
   always_comb begin
      count = '0;
      for (int l = 0; l < MAX_LAYERS; l++) begin
         count = count + CFG_W'(layer_ok[l]);
      end
   end

   assign match    = (count >= cfg.required);
   assign marks_in = capture ? '0 : ((marks_ff | hit_vec) & ~wr_vec);
   assign flag_in  = capture ? match : (shift ? flag_next : flag_ff);

   always_ff @(posedge clock) begin
      for (int l = 0; l < MAX_LAYERS; l++) begin
         if (wr_vec[l]) begin
            hash_ff[l] <= bcast.hash;
            wild_ff[l] <= bcast.wild;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         marks_ff <= marks_in;
         flag_ff  <= flag_in;
      end
   end

   assign flag = flag_ff;

endmodule

### rtl/hpgm_readout.sv
// hpgm_readout: walks the flag chain and drives the result register
// depends on hpgm_pkg
module hpgm_readout
   import hpgm_pkg::*;
#(
   parameter int unsigned NUM_GROUPS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               capture,
   input  logic               head_flag,
   output logic               shift,
   output rd_status_type      status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [GROUP_W-1:0] rsp_group_index,
   output logic               rsp_found,
   output logic               rsp_last
);

   localparam logic [GROUP_W-1:0] LAST_IDX = GROUP_W'(NUM_GROUPS - 1);

   rd_state_type       state_ff, state_in;
   logic [GROUP_W-1:0] idx_ff, idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [GROUP_W-1:0] pend_idx_ff, pend_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [GROUP_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_free;
   logic               emit;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;
      shift         = 1'b0;
      emit          = 1'b0;
      case (state_ff)
         RD_IDLE: begin
            if (capture) begin
               state_in      = RD_SCAN;
               idx_in        = '0;
               pend_valid_in = 1'b0;
            end
         end
         RD_SCAN: begin
            // a new match can only pass an older one once it has gone out
            if (!(head_flag && pend_valid_ff && !rsp_free)) begin
               shift  = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (head_flag) begin
                  if (pend_valid_ff) begin
                     emit         = 1'b1;
                     rsp_idx_in   = pend_idx_ff;
                     rsp_found_in = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = idx_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = RD_FLUSH;
               end
            end
         end
         RD_FLUSH: begin
            if (rsp_free) begin
               emit          = 1'b1;
               rsp_idx_in    = pend_valid_ff ? pend_idx_ff : '0;
               rsp_found_in  = pend_valid_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = RD_IDLE;
            end
         end
         default: begin
            state_in = RD_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= RD_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pend_idx_ff  <= pend_idx_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.busy       = (state_ff != RD_IDLE);
   assign status.pend_valid = pend_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_group_index   = rsp_idx_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
